>>> rtl/cpu_6502_core_assert.svh
// Assertion helpers for the processor core
`ifndef CPU_6502_CORE_ASSERT_SVH
`define CPU_6502_CORE_ASSERT_SVH
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> rtl/c6502_pkg.sv
`default_nettype none
package c6502_pkg;

  typedef enum logic [4:0] {
    PH_START, PH_VECLO, PH_VECHI, PH_OPCODE, PH_OP1, PH_OP2, PH_PTRLO, PH_PTRHI, PH_DATA,
    PH_WDONE, PH_PULL, PH_RTIP, PH_RETLO, PH_RETHI, PH_PUSHH, PH_PUSHL, PH_BRKP, PH_JSRHI
  } phase_e;

  typedef enum logic [3:0] {
    M_IMP, M_ACC, M_IMM, M_REL, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABSX, M_ABSY, M_IND, M_INDX,
    M_INDY
  } mode_e;

  typedef enum logic [5:0] {
    O_ADC, O_AND, O_ASL, O_BCC, O_BCS, O_BEQ, O_BIT, O_BMI, O_BNE, O_BPL, O_BRK, O_BVC, O_BVS,
    O_CLC, O_CLD, O_CLI, O_CLV, O_CMP, O_CPX, O_CPY, O_DEC, O_DEX, O_DEY, O_EOR, O_INC, O_INX,
    O_INY, O_JMP, O_JSR, O_LDA, O_LDX, O_LDY, O_LSR, O_NOP, O_ORA, O_PHA, O_PHP, O_PLA, O_PLP,
    O_ROL, O_ROR, O_RTI, O_RTS, O_SBC, O_SEC, O_SED, O_SEI, O_STA, O_STX, O_STY, O_TAX, O_TAY,
    O_TSX, O_TXA, O_TXS, O_TYA
  } op_e;

  typedef struct packed {
    logic  known;
    op_e   op;
    mode_e mode;
    logic [2:0] cyc;
  } dec_t;

  localparam logic [7:0] FL_C = 8'h01;
  localparam logic [7:0] FL_Z = 8'h02;
  localparam logic [7:0] FL_I = 8'h04;
  localparam logic [7:0] FL_D = 8'h08;
  localparam logic [7:0] FL_B = 8'h10;
  localparam logic [7:0] FL_U = 8'h20;
  localparam logic [7:0] FL_V = 8'h40;
  localparam logic [7:0] FL_N = 8'h80;

  function automatic dec_t mk(op_e o, mode_e m, logic [2:0] c);
    dec_t d;
    d.known = 1'b1; d.op = o; d.mode = m; d.cyc = c;
    return d;
  endfunction

  function automatic dec_t decode_op(logic [7:0] code);
    dec_t d;
    d = '{known: 1'b0, op: O_NOP, mode: M_IMP, cyc: 3'd0};
    case (code)
      8'h69: d = mk(O_ADC, M_IMM, 3'd2);  8'h65: d = mk(O_ADC, M_ZP, 3'd3);
      8'h75: d = mk(O_ADC, M_ZPX, 3'd4);  8'h6D: d = mk(O_ADC, M_ABS, 3'd4);
      8'h7D: d = mk(O_ADC, M_ABSX, 3'd4); 8'h79: d = mk(O_ADC, M_ABSY, 3'd4);
      8'h61: d = mk(O_ADC, M_INDX, 3'd6); 8'h71: d = mk(O_ADC, M_INDY, 3'd5);
      8'h29: d = mk(O_AND, M_IMM, 3'd2);  8'h25: d = mk(O_AND, M_ZP, 3'd3);
      8'h35: d = mk(O_AND, M_ZPX, 3'd4);  8'h2D: d = mk(O_AND, M_ABS, 3'd4);
      8'h3D: d = mk(O_AND, M_ABSX, 3'd4); 8'h39: d = mk(O_AND, M_ABSY, 3'd4);
      8'h21: d = mk(O_AND, M_INDX, 3'd6); 8'h31: d = mk(O_AND, M_INDY, 3'd5);
      8'h0A: d = mk(O_ASL, M_ACC, 3'd2);  8'h06: d = mk(O_ASL, M_ZP, 3'd5);
      8'h16: d = mk(O_ASL, M_ZPX, 3'd6);  8'h0E: d = mk(O_ASL, M_ABS, 3'd6);
      8'h1E: d = mk(O_ASL, M_ABSX, 3'd7);
      8'h90: d = mk(O_BCC, M_REL, 3'd2);  8'hB0: d = mk(O_BCS, M_REL, 3'd2);
      8'hF0: d = mk(O_BEQ, M_REL, 3'd2);  8'h30: d = mk(O_BMI, M_REL, 3'd2);
      8'hD0: d = mk(O_BNE, M_REL, 3'd2);  8'h10: d = mk(O_BPL, M_REL, 3'd2);
      8'h50: d = mk(O_BVC, M_REL, 3'd2);  8'h70: d = mk(O_BVS, M_REL, 3'd2);
      8'h24: d = mk(O_BIT, M_ZP, 3'd3);   8'h2C: d = mk(O_BIT, M_ABS, 3'd4);
      8'h00: d = mk(O_BRK, M_IMP, 3'd7);
      8'h18: d = mk(O_CLC, M_IMP, 3'd2);  8'hD8: d = mk(O_CLD, M_IMP, 3'd2);
      8'h58: d = mk(O_CLI, M_IMP, 3'd2);  8'hB8: d = mk(O_CLV, M_IMP, 3'd2);
      8'hC9: d = mk(O_CMP, M_IMM, 3'd2);  8'hC5: d = mk(O_CMP, M_ZP, 3'd3);
      8'hD5: d = mk(O_CMP, M_ZPX, 3'd4);  8'hCD: d = mk(O_CMP, M_ABS, 3'd4);
      8'hDD: d = mk(O_CMP, M_ABSX, 3'd4); 8'hD9: d = mk(O_CMP, M_ABSY, 3'd4);
      8'hC1: d = mk(O_CMP, M_INDX, 3'd6); 8'hD1: d = mk(O_CMP, M_INDY, 3'd5);
      8'hE0: d = mk(O_CPX, M_IMM, 3'd2);  8'hE4: d = mk(O_CPX, M_ZP, 3'd3);
      8'hEC: d = mk(O_CPX, M_ABS, 3'd4);
      8'hC0: d = mk(O_CPY, M_IMM, 3'd2);  8'hC4: d = mk(O_CPY, M_ZP, 3'd3);
      8'hCC: d = mk(O_CPY, M_ABS, 3'd4);
      8'hC6: d = mk(O_DEC, M_ZP, 3'd5);   8'hD6: d = mk(O_DEC, M_ZPX, 3'd6);
      8'hCE: d = mk(O_DEC, M_ABS, 3'd6);  8'hDE: d = mk(O_DEC, M_ABSX, 3'd7);
      8'hCA: d = mk(O_DEX, M_IMP, 3'd2);  8'h88: d = mk(O_DEY, M_IMP, 3'd2);
      8'h49: d = mk(O_EOR, M_IMM, 3'd2);  8'h45: d = mk(O_EOR, M_ZP, 3'd3);
      8'h55: d = mk(O_EOR, M_ZPX, 3'd4);  8'h4D: d = mk(O_EOR, M_ABS, 3'd4);
      8'h5D: d = mk(O_EOR, M_ABSX, 3'd4); 8'h59: d = mk(O_EOR, M_ABSY, 3'd4);
      8'h41: d = mk(O_EOR, M_INDX, 3'd6); 8'h51: d = mk(O_EOR, M_INDY, 3'd5);
      8'hE6: d = mk(O_INC, M_ZP, 3'd5);   8'hF6: d = mk(O_INC, M_ZPX, 3'd6);
      8'hEE: d = mk(O_INC, M_ABS, 3'd6);  8'hFE: d = mk(O_INC, M_ABSX, 3'd7);
      8'hE8: d = mk(O_INX, M_IMP, 3'd2);  8'hC8: d = mk(O_INY, M_IMP, 3'd2);
      8'h4C: d = mk(O_JMP, M_ABS, 3'd3);  8'h6C: d = mk(O_JMP, M_IND, 3'd5);
      8'h20: d = mk(O_JSR, M_ABS, 3'd6);
      8'hA9: d = mk(O_LDA, M_IMM, 3'd2);  8'hA5: d = mk(O_LDA, M_ZP, 3'd3);
      8'hB5: d = mk(O_LDA, M_ZPX, 3'd4);  8'hAD: d = mk(O_LDA, M_ABS, 3'd4);
      8'hBD: d = mk(O_LDA, M_ABSX, 3'd4); 8'hB9: d = mk(O_LDA, M_ABSY, 3'd4);
      8'hA1: d = mk(O_LDA, M_INDX, 3'd6); 8'hB1: d = mk(O_LDA, M_INDY, 3'd5);
      8'hA2: d = mk(O_LDX, M_IMM, 3'd2);  8'hA6: d = mk(O_LDX, M_ZP, 3'd3);
      8'hB6: d = mk(O_LDX, M_ZPY, 3'd4);  8'hAE: d = mk(O_LDX, M_ABS, 3'd4);
      8'hBE: d = mk(O_LDX, M_ABSY, 3'd4);
      8'hA0: d = mk(O_LDY, M_IMM, 3'd2);  8'hA4: d = mk(O_LDY, M_ZP, 3'd3);
      8'hB4: d = mk(O_LDY, M_ZPX, 3'd4);  8'hAC: d = mk(O_LDY, M_ABS, 3'd4);
      8'hBC: d = mk(O_LDY, M_ABSX, 3'd4);
      8'h4A: d = mk(O_LSR, M_ACC, 3'd2);  8'h46: d = mk(O_LSR, M_ZP, 3'd5);
      8'h56: d = mk(O_LSR, M_ZPX, 3'd6);  8'h4E: d = mk(O_LSR, M_ABS, 3'd6);
      8'h5E: d = mk(O_LSR, M_ABSX, 3'd7);
      8'hEA: d = mk(O_NOP, M_IMP, 3'd2);
      8'h09: d = mk(O_ORA, M_IMM, 3'd2);  8'h05: d = mk(O_ORA, M_ZP, 3'd3);
      8'h15: d = mk(O_ORA, M_ZPX, 3'd4);  8'h0D: d = mk(O_ORA, M_ABS, 3'd4);
      8'h1D: d = mk(O_ORA, M_ABSX, 3'd4); 8'h19: d = mk(O_ORA, M_ABSY, 3'd4);
      8'h01: d = mk(O_ORA, M_INDX, 3'd6); 8'h11: d = mk(O_ORA, M_INDY, 3'd5);
      8'h48: d = mk(O_PHA, M_IMP, 3'd3);  8'h08: d = mk(O_PHP, M_IMP, 3'd3);
      8'h68: d = mk(O_PLA, M_IMP, 3'd4);  8'h28: d = mk(O_PLP, M_IMP, 3'd4);
      8'h2A: d = mk(O_ROL, M_ACC, 3'd2);  8'h26: d = mk(O_ROL, M_ZP, 3'd5);
      8'h36: d = mk(O_ROL, M_ZPX, 3'd6);  8'h2E: d = mk(O_ROL, M_ABS, 3'd6);
      8'h3E: d = mk(O_ROL, M_ABSX, 3'd7);
      8'h6A: d = mk(O_ROR, M_ACC, 3'd2);  8'h66: d = mk(O_ROR, M_ZP, 3'd5);
      8'h76: d = mk(O_ROR, M_ZPX, 3'd6);  8'h6E: d = mk(O_ROR, M_ABS, 3'd6);
      8'h7E: d = mk(O_ROR, M_ABSX, 3'd7);
      8'h40: d = mk(O_RTI, M_IMP, 3'd6);  8'h60: d = mk(O_RTS, M_IMP, 3'd6);
      8'hE9: d = mk(O_SBC, M_IMM, 3'd2);  8'hE5: d = mk(O_SBC, M_ZP, 3'd3);
      8'hF5: d = mk(O_SBC, M_ZPX, 3'd4);  8'hED: d = mk(O_SBC, M_ABS, 3'd4);
      8'hFD: d = mk(O_SBC, M_ABSX, 3'd4); 8'hF9: d = mk(O_SBC, M_ABSY, 3'd4);
      8'hE1: d = mk(O_SBC, M_INDX, 3'd6); 8'hF1: d = mk(O_SBC, M_INDY, 3'd5);
      8'h38: d = mk(O_SEC, M_IMP, 3'd2);  8'hF8: d = mk(O_SED, M_IMP, 3'd2);
      8'h78: d = mk(O_SEI, M_IMP, 3'd2);
      8'h85: d = mk(O_STA, M_ZP, 3'd3);   8'h95: d = mk(O_STA, M_ZPX, 3'd4);
      8'h8D: d = mk(O_STA, M_ABS, 3'd4);  8'h9D: d = mk(O_STA, M_ABSX, 3'd5);
      8'h99: d = mk(O_STA, M_ABSY, 3'd5); 8'h81: d = mk(O_STA, M_INDX, 3'd6);
      8'h91: d = mk(O_STA, M_INDY, 3'd6);
      8'h86: d = mk(O_STX, M_ZP, 3'd3);   8'h96: d = mk(O_STX, M_ZPY, 3'd4);
      8'h8E: d = mk(O_STX, M_ABS, 3'd4);
      8'h84: d = mk(O_STY, M_ZP, 3'd3);   8'h94: d = mk(O_STY, M_ZPX, 3'd4);
      8'h8C: d = mk(O_STY, M_ABS, 3'd4);
      8'hAA: d = mk(O_TAX, M_IMP, 3'd2);  8'hA8: d = mk(O_TAY, M_IMP, 3'd2);
      8'hBA: d = mk(O_TSX, M_IMP, 3'd2);  8'h8A: d = mk(O_TXA, M_IMP, 3'd2);
      8'h9A: d = mk(O_TXS, M_IMP, 3'd2);  8'h98: d = mk(O_TYA, M_IMP, 3'd2);
      default: d = '{known: 1'b0, op: O_NOP, mode: M_IMP, cyc: 3'd0};
    endcase
    return d;
  endfunction

  function automatic logic is_read_op(op_e o);
    return o == O_ADC || o == O_AND || o == O_BIT || o == O_CMP || o == O_CPX ||
           o == O_CPY || o == O_EOR || o == O_LDA || o == O_LDX || o == O_LDY ||
           o == O_ORA || o == O_SBC;
  endfunction

  function automatic logic is_store_op(op_e o);
    return o == O_STA || o == O_STX || o == O_STY;
  endfunction

  function automatic logic [7:0] with_nz(logic [7:0] p, logic [7:0] v);
    logic [7:0] r;
    r = p & ~(FL_Z | FL_N);
    if (v == 8'h00) r = r | FL_Z;
    if (v[7]) r = r | FL_N;
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/c6502_alu.sv
`default_nettype none
module c6502_alu (
  input  var c6502_pkg::op_e op_i,
  input  wire  [7:0]  acc_i,
  input  wire  [7:0]  x_i,
  input  wire  [7:0]  y_i,
  input  wire  [7:0]  p_i,
  input  wire  [7:0]  v_i,
  output logic [7:0]  acc_o,
  output logic [7:0]  x_o,
  output logic [7:0]  y_o,
  output logic [7:0]  p_o,
  output logic [7:0]  mod_o
);
  import c6502_pkg::*;

  logic [7:0] addend;
  logic [8:0] sum;
  logic [8:0] diff;
  logic [7:0] cmp_reg;
  logic       cin;

  assign cin = p_i[0];
  assign addend = (op_i == O_SBC) ? ~v_i : v_i;
  assign sum = {1'b0, acc_i} + {1'b0, addend} + {8'h00, cin};
  assign cmp_reg = (op_i == O_CPX) ? x_i : ((op_i == O_CPY) ? y_i : acc_i);
  assign diff = {1'b0, cmp_reg} - {1'b0, v_i};

  // read operations and shift or step on a memory word
  always_comb begin
    acc_o = acc_i;
    x_o = x_i;
    y_o = y_i;
    p_o = p_i;
    mod_o = v_i;
    case (op_i)
      O_ADC, O_SBC: begin
        acc_o = sum[7:0];
        p_o = with_nz(p_i, sum[7:0]) & ~(FL_C | FL_V);
        if (sum[8]) p_o = p_o | FL_C;
        if ((~(acc_i[7] ^ addend[7])) & (acc_i[7] ^ sum[7])) p_o = p_o | FL_V;
      end
      O_AND: begin acc_o = acc_i & v_i; p_o = with_nz(p_i, acc_i & v_i); end
      O_ORA: begin acc_o = acc_i | v_i; p_o = with_nz(p_i, acc_i | v_i); end
      O_EOR: begin acc_o = acc_i ^ v_i; p_o = with_nz(p_i, acc_i ^ v_i); end
      O_LDA: begin acc_o = v_i; p_o = with_nz(p_i, v_i); end
      O_LDX: begin x_o = v_i; p_o = with_nz(p_i, v_i); end
      O_LDY: begin y_o = v_i; p_o = with_nz(p_i, v_i); end
      O_CMP, O_CPX, O_CPY: begin
        p_o = with_nz(p_i, diff[7:0]) & ~FL_C;
        if (!diff[8]) p_o = p_o | FL_C;
      end
      O_BIT: begin
        p_o = p_i & ~(FL_Z | FL_V | FL_N);
        if ((acc_i & v_i) == 8'h00) p_o = p_o | FL_Z;
        p_o = p_o | (v_i & (FL_V | FL_N));
      end
      O_ASL: begin
        mod_o = {v_i[6:0], 1'b0};
        p_o = (with_nz(p_i, {v_i[6:0], 1'b0}) & ~FL_C) | {7'h00, v_i[7]};
      end
      O_LSR: begin
        mod_o = {1'b0, v_i[7:1]};
        p_o = (with_nz(p_i, {1'b0, v_i[7:1]}) & ~FL_C) | {7'h00, v_i[0]};
      end
      O_ROL: begin
        mod_o = {v_i[6:0], cin};
        p_o = (with_nz(p_i, {v_i[6:0], cin}) & ~FL_C) | {7'h00, v_i[7]};
      end
      O_ROR: begin
        mod_o = {cin, v_i[7:1]};
        p_o = (with_nz(p_i, {cin, v_i[7:1]}) & ~FL_C) | {7'h00, v_i[0]};
      end
      O_INC: begin mod_o = v_i + 8'h01; p_o = with_nz(p_i, v_i + 8'h01); end
      O_DEC: begin mod_o = v_i - 8'h01; p_o = with_nz(p_i, v_i - 8'h01); end
      default: begin end
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/cpu_6502_core.sv
// 6502 core without decimal mode; one bus access per accepted word.
// An access request is registered on acceptance; a held result stalls input.
// Otherwise one word per cycle, set by the single registered sequencer step.
// Reset: rst_ni clears all but the result word; the first word after reset,
// or any word with kind_i set, restarts the core at the vector read of FFFC.
`default_nettype none
`include "cpu_6502_core_assert.svh"
module cpu_6502_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire         kind_i,
  input  wire  [7:0]  read_data_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [15:0] bus_address_o,
  output logic        bus_write_o,
  output logic [7:0]  write_data_o,
  output logic        opcode_fetch_o,
  output logic [2:0]  instruction_cycles_o,
  output logic        halted_o
);
  import c6502_pkg::*;

  // architectural and sequencer state
  logic [7:0]  a_q, a_d, x_q, x_d, y_q, y_d, sp_q, sp_d, p_q, p_d;
  logic [15:0] pc_q, pc_d, ea_q, ea_d;
  logic [7:0]  opb_q, opb_d;
  logic [2:0]  tally_q, tally_d;
  logic        halt_q, halt_d;
  op_e         op_q, op_d;
  mode_e       mode_q, mode_d;
  phase_e      ph_q, ph_d;

  // result register
  logic [15:0] addr_d;
  logic        wr_d, fetch_d;
  logic [7:0]  wdat_d;

  logic        take;
  dec_t        dec;
  logic [7:0]  v;

  // ALU: opcode operand (immediate/data) or accumulator for accumulator shifts
  op_e         alu_op;
  logic [7:0]  alu_v, alu_a, alu_x, alu_y, alu_p, alu_mod;

  // the output register frees whenever it is empty or being taken
  assign in_stall_o = out_valid_o & out_stall_i;
  assign take = in_valid_i & ~in_stall_o;
  assign v = read_data_i;
  assign dec = decode_op(v);

  assign alu_op = (ph_q == PH_OPCODE) ? dec.op : op_q;
  assign alu_v  = (ph_q == PH_OPCODE) ? a_q : v;

  c6502_alu u_alu (
    .op_i (alu_op), .acc_i(a_q), .x_i(x_q), .y_i(y_q), .p_i(p_q), .v_i(alu_v),
    .acc_o(alu_a), .x_o(alu_x), .y_o(alu_y), .p_o(alu_p), .mod_o(alu_mod)
  );

  logic [15:0] pc1, base, idx_sum, br_tgt;
  logic [7:0]  idx, st_val;
  logic        br_taken;

  assign pc1 = pc_q + 16'h0001;
  assign base = {v, opb_q};
  assign idx = ((mode_q == M_ABSX) && (ph_q == PH_OP2)) ? x_q : y_q;
  assign idx_sum = base + {8'h00, idx};
  assign br_tgt = pc1 + {{8{v[7]}}, v};
  assign st_val = (op_q == O_STA) ? a_q : ((op_q == O_STX) ? x_q : y_q);

  always_comb begin
    case (op_q)
      O_BPL: br_taken = ~p_q[7];
      O_BMI: br_taken = p_q[7];
      O_BVC: br_taken = ~p_q[6];
      O_BVS: br_taken = p_q[6];
      O_BCC: br_taken = ~p_q[0];
      O_BCS: br_taken = p_q[0];
      O_BNE: br_taken = ~p_q[1];
      default: br_taken = p_q[1];
    endcase
  end

  always_comb begin
    a_d = a_q; x_d = x_q; y_d = y_q; sp_d = sp_q; p_d = p_q;
    pc_d = pc_q; ea_d = ea_q; opb_d = opb_q; tally_d = tally_q; halt_d = halt_q;
    op_d = op_q; mode_d = mode_q; ph_d = ph_q;
    addr_d = pc_q; wr_d = 1'b0; wdat_d = 8'h00; fetch_d = 1'b0;
    if (kind_i || ph_q == PH_START) begin
      a_d = 8'h00; x_d = 8'h00; y_d = 8'h00; sp_d = 8'hFD; p_d = 8'h24;
      pc_d = 16'h0000; opb_d = 8'h00; tally_d = 3'd0; halt_d = 1'b0;
      op_d = O_NOP; mode_d = M_IMP; ea_d = 16'hFFFC;
      addr_d = 16'hFFFC; ph_d = PH_VECLO;
    end else if (halt_q) begin
      addr_d = pc_q;
    end else begin
      case (ph_q)
        PH_VECLO: begin
          opb_d = v; addr_d = ea_q + 16'h0001; ph_d = PH_VECHI;
        end
        PH_VECHI, PH_JSRHI, PH_RETHI: begin
          pc_d = {v, opb_q};
          if (ph_q == PH_RETHI && op_q == O_RTS) pc_d = {v, opb_q} + 16'h0001;
          addr_d = pc_d; fetch_d = 1'b1; ph_d = PH_OPCODE;
        end
        PH_OPCODE: begin
          if (!dec.known) begin
            halt_d = 1'b1; addr_d = pc_q;
          end else begin
            op_d = dec.op; mode_d = dec.mode; tally_d = dec.cyc; pc_d = pc1;
            addr_d = pc1; ph_d = PH_OP1;
            if (dec.mode == M_ACC) begin
              a_d = alu_mod; p_d = alu_p; fetch_d = 1'b1; ph_d = PH_OPCODE;
            end else if (dec.mode == M_IMP) begin
              fetch_d = 1'b1; ph_d = PH_OPCODE;
              case (dec.op)
                O_BRK: begin
                  pc_d = pc_q + 16'h0002; addr_d = {8'h01, sp_q}; wr_d = 1'b1;
                  wdat_d = pc_d[15:8]; sp_d = sp_q - 8'h01; fetch_d = 1'b0; ph_d = PH_PUSHH;
                end
                O_PHA, O_PHP: begin
                  addr_d = {8'h01, sp_q}; wr_d = 1'b1; sp_d = sp_q - 8'h01; fetch_d = 1'b0;
                  wdat_d = (dec.op == O_PHA) ? a_q : (p_q | FL_B | FL_U); ph_d = PH_WDONE;
                end
                O_RTS, O_RTI, O_PLA, O_PLP: begin
                  sp_d = sp_q + 8'h01; addr_d = {8'h01, sp_d}; fetch_d = 1'b0;
                  ph_d = (dec.op == O_RTS) ? PH_RETLO :
                         ((dec.op == O_RTI) ? PH_RTIP : PH_PULL);
                end
                O_CLC: p_d = p_q & ~FL_C;
                O_SEC: p_d = p_q | FL_C;
                O_CLI: p_d = p_q & ~FL_I;
                O_SEI: p_d = p_q | FL_I;
                O_CLD: p_d = p_q & ~FL_D;
                O_SED: p_d = p_q | FL_D;
                O_CLV: p_d = p_q & ~FL_V;
                O_DEX: begin x_d = x_q - 8'h01; p_d = with_nz(p_q, x_d); end
                O_DEY: begin y_d = y_q - 8'h01; p_d = with_nz(p_q, y_d); end
                O_INX: begin x_d = x_q + 8'h01; p_d = with_nz(p_q, x_d); end
                O_INY: begin y_d = y_q + 8'h01; p_d = with_nz(p_q, y_d); end
                O_TAX: begin x_d = a_q; p_d = with_nz(p_q, a_q); end
                O_TAY: begin y_d = a_q; p_d = with_nz(p_q, a_q); end
                O_TXA: begin a_d = x_q; p_d = with_nz(p_q, x_q); end
                O_TYA: begin a_d = y_q; p_d = with_nz(p_q, y_q); end
                O_TSX: begin x_d = sp_q; p_d = with_nz(p_q, sp_q); end
                O_TXS: sp_d = x_q;
                default: begin end
              endcase
            end
          end
        end
        PH_OP1: begin
          pc_d = pc1;
          addr_d = pc1; fetch_d = 1'b1; ph_d = PH_OPCODE;
          case (mode_q)
            M_IMM: begin a_d = alu_a; x_d = alu_x; y_d = alu_y; p_d = alu_p; end
            M_REL: begin
              if (br_taken) begin
                pc_d = br_tgt; addr_d = br_tgt;
                tally_d = tally_q + 3'd1 + {2'b00, (br_tgt[15:8] != pc1[15:8])};
              end
            end
            M_ZP, M_ZPX, M_ZPY: begin
              ea_d = {8'h00, v + ((mode_q == M_ZPX) ? x_q :
                                  ((mode_q == M_ZPY) ? y_q : 8'h00))};
              addr_d = ea_d; fetch_d = 1'b0;
              if (is_store_op(op_q)) begin
                wr_d = 1'b1; wdat_d = st_val; ph_d = PH_WDONE;
              end else ph_d = PH_DATA;
            end
            M_INDX, M_INDY: begin
              ea_d = {8'h00, v + ((mode_q == M_INDX) ? x_q : 8'h00)};
              addr_d = ea_d; fetch_d = 1'b0; ph_d = PH_PTRLO;
            end
            default: begin
              opb_d = v; fetch_d = 1'b0;
              if (op_q == O_JSR) begin
                addr_d = {8'h01, sp_q}; wr_d = 1'b1; wdat_d = pc1[15:8];
                sp_d = sp_q - 8'h01; ph_d = PH_PUSHH;
              end else ph_d = PH_OP2;
            end
          endcase
        end
        PH_OP2, PH_PTRHI: begin
          if (ph_q == PH_OP2) pc_d = pc1;
          fetch_d = 1'b0;
          ea_d = base;
          if ((mode_q == M_ABSX || mode_q == M_ABSY) && ph_q == PH_OP2 ||
              mode_q == M_INDY && ph_q == PH_PTRHI) begin
            ea_d = idx_sum;
            if (is_read_op(op_q) && idx_sum[15:8] != base[15:8]) tally_d = tally_q + 3'd1;
          end
          if (mode_q == M_IND && ph_q == PH_OP2) begin
            addr_d = base; ph_d = PH_PTRLO;
          end else if (op_q == O_JMP) begin
            pc_d = base; addr_d = base; fetch_d = 1'b1; ph_d = PH_OPCODE;
          end else begin
            addr_d = ea_d;
            if (is_store_op(op_q)) begin
              wr_d = 1'b1; wdat_d = st_val; ph_d = PH_WDONE;
            end else ph_d = PH_DATA;
          end
        end
        PH_PTRLO: begin
          opb_d = v; addr_d = {ea_q[15:8], ea_q[7:0] + 8'h01}; ph_d = PH_PTRHI;
        end
        PH_DATA: begin
          p_d = alu_p;
          if (is_read_op(op_q)) begin
            a_d = alu_a; x_d = alu_x; y_d = alu_y;
            addr_d = pc_q; fetch_d = 1'b1; ph_d = PH_OPCODE;
          end else begin
            addr_d = ea_q; wr_d = 1'b1; wdat_d = alu_mod; ph_d = PH_WDONE;
          end
        end
        PH_WDONE: begin
          addr_d = pc_q; fetch_d = 1'b1; ph_d = PH_OPCODE;
        end
        PH_PULL: begin
          if (op_q == O_PLA) begin
            a_d = v; p_d = with_nz(p_q, v);
          end else p_d = (v & ~FL_B) | FL_U;
          addr_d = pc_q; fetch_d = 1'b1; ph_d = PH_OPCODE;
        end
        PH_RTIP, PH_RETLO: begin
          if (ph_q == PH_RTIP) p_d = (v & ~FL_B) | FL_U;
          else opb_d = v;
          sp_d = sp_q + 8'h01; addr_d = {8'h01, sp_d};
          ph_d = (ph_q == PH_RTIP) ? PH_RETLO : PH_RETHI;
        end
        PH_PUSHH: begin
          addr_d = {8'h01, sp_q}; wr_d = 1'b1; wdat_d = pc_q[7:0];
          sp_d = sp_q - 8'h01; ph_d = PH_PUSHL;
        end
        PH_PUSHL: begin
          if (op_q == O_JSR) begin
            addr_d = pc_q; ph_d = PH_JSRHI;
          end else begin
            addr_d = {8'h01, sp_q}; wr_d = 1'b1; wdat_d = p_q | FL_B | FL_U;
            sp_d = sp_q - 8'h01; ph_d = PH_BRKP;
          end
        end
        PH_BRKP: begin
          p_d = p_q | FL_I; ea_d = 16'hFFFE; addr_d = 16'hFFFE; ph_d = PH_VECLO;
        end
        default: begin end
      endcase
    end
  end

  // hold state between words; advance only on an accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= 8'h00; x_q <= 8'h00; y_q <= 8'h00; sp_q <= 8'hFD; p_q <= 8'h24;
      pc_q <= 16'h0000; ea_q <= 16'h0000; opb_q <= 8'h00; tally_q <= 3'd0;
      halt_q <= 1'b0; op_q <= O_NOP; mode_q <= M_IMP; ph_q <= PH_START;
      out_valid_o <= 1'b0;
    end else begin
      if (take) begin
        a_q <= a_d; x_q <= x_d; y_q <= y_d; sp_q <= sp_d; p_q <= p_d;
        pc_q <= pc_d; ea_q <= ea_d; opb_q <= opb_d; tally_q <= tally_d;
        halt_q <= halt_d; op_q <= op_d; mode_q <= mode_d; ph_q <= ph_d;
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // result word register; loaded only on acceptance, so a stalled word holds
  always_ff @(posedge clk_i) begin
    if (take) begin
      bus_address_o <= addr_d;
      bus_write_o <= wr_d;
      write_data_o <= wdat_d;
      opcode_fetch_o <= fetch_d;
      instruction_cycles_o <= fetch_d ? tally_d : 3'd0;
      halted_o <= halt_d;
    end
  end

  // a word is never taken while the waiting result is held
  `ASSERT_IMPL(a_no_overrun, clk_i, rst_ni, out_valid_o && out_stall_i, !take)
  // an accepted word always yields a result next cycle
  `ASSERT_NEXT(a_result, clk_i, rst_ni, take, out_valid_o)
  // a halted core only ever issues reads
  `ASSERT_IMPL(a_halt_read, clk_i, rst_ni, out_valid_o && halted_o,
               !bus_write_o && !opcode_fetch_o)
endmodule
`default_nettype wire

>>> sim/tb.sv
module tb;
  import c6502_pkg::*;

  localparam int unsigned RandomWords = 1800;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned HoldOffLen  = 400;

  // One predicted bus access: everything the core shows on its result channel.
  typedef struct packed {
    logic [15:0] addr;
    logic        wr;
    logic [7:0]  wdata;
    logic        fetch;
    logic [2:0]  cycles;
    logic        halted;
  } access_t;

  // One line of the instruction table.
  typedef struct packed {
    logic       known;
    op_e        op;
    mode_e      mode;
    logic [2:0] cyc;
  } opinfo_t;

  function automatic opinfo_t oi(op_e o, mode_e m, logic [2:0] c);
    opinfo_t r;
    r.known = 1'b1; r.op = o; r.mode = m; r.cyc = c;
    return r;
  endfunction

  // Documented NMOS opcodes only; anything else halts the core.
  function automatic opinfo_t opcode_info(logic [7:0] code);
    opinfo_t e;
    e = '{known: 1'b0, op: O_NOP, mode: M_IMP, cyc: 3'd0};
    case (code)
      8'h69: e = oi(O_ADC, M_IMM, 2);  8'h65: e = oi(O_ADC, M_ZP, 3);
      8'h75: e = oi(O_ADC, M_ZPX, 4);  8'h6D: e = oi(O_ADC, M_ABS, 4);
      8'h7D: e = oi(O_ADC, M_ABSX, 4); 8'h79: e = oi(O_ADC, M_ABSY, 4);
      8'h61: e = oi(O_ADC, M_INDX, 6); 8'h71: e = oi(O_ADC, M_INDY, 5);
      8'h29: e = oi(O_AND, M_IMM, 2);  8'h25: e = oi(O_AND, M_ZP, 3);
      8'h35: e = oi(O_AND, M_ZPX, 4);  8'h2D: e = oi(O_AND, M_ABS, 4);
      8'h3D: e = oi(O_AND, M_ABSX, 4); 8'h39: e = oi(O_AND, M_ABSY, 4);
      8'h21: e = oi(O_AND, M_INDX, 6); 8'h31: e = oi(O_AND, M_INDY, 5);
      8'h0A: e = oi(O_ASL, M_ACC, 2);  8'h06: e = oi(O_ASL, M_ZP, 5);
      8'h16: e = oi(O_ASL, M_ZPX, 6);  8'h0E: e = oi(O_ASL, M_ABS, 6);
      8'h1E: e = oi(O_ASL, M_ABSX, 7);
      8'h90: e = oi(O_BCC, M_REL, 2);  8'hB0: e = oi(O_BCS, M_REL, 2);
      8'hF0: e = oi(O_BEQ, M_REL, 2);  8'h30: e = oi(O_BMI, M_REL, 2);
      8'hD0: e = oi(O_BNE, M_REL, 2);  8'h10: e = oi(O_BPL, M_REL, 2);
      8'h50: e = oi(O_BVC, M_REL, 2);  8'h70: e = oi(O_BVS, M_REL, 2);
      8'h24: e = oi(O_BIT, M_ZP, 3);   8'h2C: e = oi(O_BIT, M_ABS, 4);
      8'h00: e = oi(O_BRK, M_IMP, 7);
      8'h18: e = oi(O_CLC, M_IMP, 2);  8'hD8: e = oi(O_CLD, M_IMP, 2);
      8'h58: e = oi(O_CLI, M_IMP, 2);  8'hB8: e = oi(O_CLV, M_IMP, 2);
      8'hC9: e = oi(O_CMP, M_IMM, 2);  8'hC5: e = oi(O_CMP, M_ZP, 3);
      8'hD5: e = oi(O_CMP, M_ZPX, 4);  8'hCD: e = oi(O_CMP, M_ABS, 4);
      8'hDD: e = oi(O_CMP, M_ABSX, 4); 8'hD9: e = oi(O_CMP, M_ABSY, 4);
      8'hC1: e = oi(O_CMP, M_INDX, 6); 8'hD1: e = oi(O_CMP, M_INDY, 5);
      8'hE0: e = oi(O_CPX, M_IMM, 2);  8'hE4: e = oi(O_CPX, M_ZP, 3);
      8'hEC: e = oi(O_CPX, M_ABS, 4);
      8'hC0: e = oi(O_CPY, M_IMM, 2);  8'hC4: e = oi(O_CPY, M_ZP, 3);
      8'hCC: e = oi(O_CPY, M_ABS, 4);
      8'hC6: e = oi(O_DEC, M_ZP, 5);   8'hD6: e = oi(O_DEC, M_ZPX, 6);
      8'hCE: e = oi(O_DEC, M_ABS, 6);  8'hDE: e = oi(O_DEC, M_ABSX, 7);
      8'hCA: e = oi(O_DEX, M_IMP, 2);  8'h88: e = oi(O_DEY, M_IMP, 2);
      8'h49: e = oi(O_EOR, M_IMM, 2);  8'h45: e = oi(O_EOR, M_ZP, 3);
      8'h55: e = oi(O_EOR, M_ZPX, 4);  8'h4D: e = oi(O_EOR, M_ABS, 4);
      8'h5D: e = oi(O_EOR, M_ABSX, 4); 8'h59: e = oi(O_EOR, M_ABSY, 4);
      8'h41: e = oi(O_EOR, M_INDX, 6); 8'h51: e = oi(O_EOR, M_INDY, 5);
      8'hE6: e = oi(O_INC, M_ZP, 5);   8'hF6: e = oi(O_INC, M_ZPX, 6);
      8'hEE: e = oi(O_INC, M_ABS, 6);  8'hFE: e = oi(O_INC, M_ABSX, 7);
      8'hE8: e = oi(O_INX, M_IMP, 2);  8'hC8: e = oi(O_INY, M_IMP, 2);
      8'h4C: e = oi(O_JMP, M_ABS, 3);  8'h6C: e = oi(O_JMP, M_IND, 5);
      8'h20: e = oi(O_JSR, M_ABS, 6);
      8'hA9: e = oi(O_LDA, M_IMM, 2);  8'hA5: e = oi(O_LDA, M_ZP, 3);
      8'hB5: e = oi(O_LDA, M_ZPX, 4);  8'hAD: e = oi(O_LDA, M_ABS, 4);
      8'hBD: e = oi(O_LDA, M_ABSX, 4); 8'hB9: e = oi(O_LDA, M_ABSY, 4);
      8'hA1: e = oi(O_LDA, M_INDX, 6); 8'hB1: e = oi(O_LDA, M_INDY, 5);
      8'hA2: e = oi(O_LDX, M_IMM, 2);  8'hA6: e = oi(O_LDX, M_ZP, 3);
      8'hB6: e = oi(O_LDX, M_ZPY, 4);  8'hAE: e = oi(O_LDX, M_ABS, 4);
      8'hBE: e = oi(O_LDX, M_ABSY, 4);
      8'hA0: e = oi(O_LDY, M_IMM, 2);  8'hA4: e = oi(O_LDY, M_ZP, 3);
      8'hB4: e = oi(O_LDY, M_ZPX, 4);  8'hAC: e = oi(O_LDY, M_ABS, 4);
      8'hBC: e = oi(O_LDY, M_ABSX, 4);
      8'h4A: e = oi(O_LSR, M_ACC, 2);  8'h46: e = oi(O_LSR, M_ZP, 5);
      8'h56: e = oi(O_LSR, M_ZPX, 6);  8'h4E: e = oi(O_LSR, M_ABS, 6);
      8'h5E: e = oi(O_LSR, M_ABSX, 7);
      8'hEA: e = oi(O_NOP, M_IMP, 2);
      8'h09: e = oi(O_ORA, M_IMM, 2);  8'h05: e = oi(O_ORA, M_ZP, 3);
      8'h15: e = oi(O_ORA, M_ZPX, 4);  8'h0D: e = oi(O_ORA, M_ABS, 4);
      8'h1D: e = oi(O_ORA, M_ABSX, 4); 8'h19: e = oi(O_ORA, M_ABSY, 4);
      8'h01: e = oi(O_ORA, M_INDX, 6); 8'h11: e = oi(O_ORA, M_INDY, 5);
      8'h48: e = oi(O_PHA, M_IMP, 3);  8'h08: e = oi(O_PHP, M_IMP, 3);
      8'h68: e = oi(O_PLA, M_IMP, 4);  8'h28: e = oi(O_PLP, M_IMP, 4);
      8'h2A: e = oi(O_ROL, M_ACC, 2);  8'h26: e = oi(O_ROL, M_ZP, 5);
      8'h36: e = oi(O_ROL, M_ZPX, 6);  8'h2E: e = oi(O_ROL, M_ABS, 6);
      8'h3E: e = oi(O_ROL, M_ABSX, 7);
      8'h6A: e = oi(O_ROR, M_ACC, 2);  8'h66: e = oi(O_ROR, M_ZP, 5);
      8'h76: e = oi(O_ROR, M_ZPX, 6);  8'h6E: e = oi(O_ROR, M_ABS, 6);
      8'h7E: e = oi(O_ROR, M_ABSX, 7);
      8'h40: e = oi(O_RTI, M_IMP, 6);  8'h60: e = oi(O_RTS, M_IMP, 6);
      8'hE9: e = oi(O_SBC, M_IMM, 2);  8'hE5: e = oi(O_SBC, M_ZP, 3);
      8'hF5: e = oi(O_SBC, M_ZPX, 4);  8'hED: e = oi(O_SBC, M_ABS, 4);
      8'hFD: e = oi(O_SBC, M_ABSX, 4); 8'hF9: e = oi(O_SBC, M_ABSY, 4);
      8'hE1: e = oi(O_SBC, M_INDX, 6); 8'hF1: e = oi(O_SBC, M_INDY, 5);
      8'h38: e = oi(O_SEC, M_IMP, 2);  8'hF8: e = oi(O_SED, M_IMP, 2);
      8'h78: e = oi(O_SEI, M_IMP, 2);
      8'h85: e = oi(O_STA, M_ZP, 3);   8'h95: e = oi(O_STA, M_ZPX, 4);
      8'h8D: e = oi(O_STA, M_ABS, 4);  8'h9D: e = oi(O_STA, M_ABSX, 5);
      8'h99: e = oi(O_STA, M_ABSY, 5); 8'h81: e = oi(O_STA, M_INDX, 6);
      8'h91: e = oi(O_STA, M_INDY, 6);
      8'h86: e = oi(O_STX, M_ZP, 3);   8'h96: e = oi(O_STX, M_ZPY, 4);
      8'h8E: e = oi(O_STX, M_ABS, 4);
      8'h84: e = oi(O_STY, M_ZP, 3);   8'h94: e = oi(O_STY, M_ZPX, 4);
      8'h8C: e = oi(O_STY, M_ABS, 4);
      8'hAA: e = oi(O_TAX, M_IMP, 2);  8'hA8: e = oi(O_TAY, M_IMP, 2);
      8'hBA: e = oi(O_TSX, M_IMP, 2);  8'h8A: e = oi(O_TXA, M_IMP, 2);
      8'h9A: e = oi(O_TXS, M_IMP, 2);  8'h98: e = oi(O_TYA, M_IMP, 2);
      default: ;
    endcase
    return e;
  endfunction

  // Shadow processor: steps once per accepted word and queues the bus access
  // the core must request next; checks each access the core hands out.
  class bus_predictor;
    logic [7:0]  acc, rx, ry, sp, ps, opnd, tally;
    logic [15:0] pc, ea;
    logic        halt;
    op_e         op;
    mode_e       mode;
    phase_e      step;
    access_t     nxt;
    access_t     pending_access[$];
    int unsigned mismatches;

    function new();
      step = PH_START;
      halt = 1'b0;
      nxt = '0;
      mismatches = 0;
    endfunction

    function void report(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch on %s: got %h, want %h", what, got, want);
      mismatches++;
    endfunction

    function void rd(logic [15:0] a, phase_e ph);
      nxt.addr = a; nxt.wr = 1'b0; nxt.wdata = 8'h00; nxt.fetch = 1'b0; step = ph;
    endfunction

    function void wr(logic [15:0] a, logic [7:0] d, phase_e ph);
      nxt.addr = a; nxt.wr = 1'b1; nxt.wdata = d; nxt.fetch = 1'b0; step = ph;
    endfunction

    function void opfetch();
      nxt.addr = pc; nxt.wr = 1'b0; nxt.wdata = 8'h00; nxt.fetch = 1'b1; step = PH_OPCODE;
    endfunction

    function void push(logic [7:0] d, phase_e ph);
      wr({8'h01, sp}, d, ph);
      sp = sp - 8'd1;
    endfunction

    function void pull(phase_e ph);
      sp = sp + 8'd1;
      rd({8'h01, sp}, ph);
    endfunction

    function void setf(logic [7:0] f, logic on);
      ps = on ? (ps | f) : (ps & ~f);
    endfunction

    function void setnz(logic [7:0] v);
      setf(FL_Z, v == 8'h00);
      setf(FL_N, v[7]);
    endfunction

    function logic loads(op_e o);
      return o inside {O_ADC, O_AND, O_BIT, O_CMP, O_CPX, O_CPY, O_EOR, O_LDA, O_LDX,
                       O_LDY, O_ORA, O_SBC};
    endfunction

    function void add_carry(logic [7:0] v);
      logic [8:0] sum;
      sum = {1'b0, acc} + {1'b0, v} + {8'h00, ps[0]};
      setf(FL_C, sum[8]);
      setf(FL_V, (~(acc ^ v) & (acc ^ sum[7:0]) & 8'h80) != 8'h00);
      acc = sum[7:0];
      setnz(acc);
    endfunction

    function void compare(logic [7:0] r, logic [7:0] v);
      setf(FL_C, r >= v);
      setnz(r - v);
    endfunction

    function void use_operand(logic [7:0] v);
      case (op)
        O_ADC: add_carry(v);
        O_SBC: add_carry(~v);
        O_AND: begin acc = acc & v; setnz(acc); end
        O_ORA: begin acc = acc | v; setnz(acc); end
        O_EOR: begin acc = acc ^ v; setnz(acc); end
        O_LDA: begin acc = v; setnz(v); end
        O_LDX: begin rx = v; setnz(v); end
        O_LDY: begin ry = v; setnz(v); end
        O_CMP: compare(acc, v);
        O_CPX: compare(rx, v);
        O_CPY: compare(ry, v);
        O_BIT: begin
          setf(FL_Z, (acc & v) == 8'h00);
          setf(FL_V, v[6]);
          setf(FL_N, v[7]);
        end
        default: ;
      endcase
    endfunction

    function logic [7:0] shift_or_step(logic [7:0] v);
      logic [7:0] r;
      r = v;
      case (op)
        O_ASL: begin r = {v[6:0], 1'b0}; setf(FL_C, v[7]); end
        O_LSR: begin r = {1'b0, v[7:1]}; setf(FL_C, v[0]); end
        O_ROL: begin r = {v[6:0], ps[0]}; setf(FL_C, v[7]); end
        O_ROR: begin r = {ps[0], v[7:1]}; setf(FL_C, v[0]); end
        O_INC: r = v + 8'd1;
        O_DEC: r = v - 8'd1;
        default: ;
      endcase
      setnz(r);
      return r;
    endfunction

    function void run_implied();
      case (op)
        O_CLC: setf(FL_C, 1'b0);
        O_SEC: setf(FL_C, 1'b1);
        O_CLI: setf(FL_I, 1'b0);
        O_SEI: setf(FL_I, 1'b1);
        O_CLD: setf(FL_D, 1'b0);
        O_SED: setf(FL_D, 1'b1);
        O_CLV: setf(FL_V, 1'b0);
        O_DEX: begin rx = rx - 8'd1; setnz(rx); end
        O_DEY: begin ry = ry - 8'd1; setnz(ry); end
        O_INX: begin rx = rx + 8'd1; setnz(rx); end
        O_INY: begin ry = ry + 8'd1; setnz(ry); end
        O_TAX: begin rx = acc; setnz(rx); end
        O_TAY: begin ry = acc; setnz(ry); end
        O_TXA: begin acc = rx; setnz(acc); end
        O_TYA: begin acc = ry; setnz(acc); end
        O_TSX: begin rx = sp; setnz(rx); end
        O_TXS: sp = rx;
        default: ;
      endcase
    endfunction

    function logic taken();
      case (op)
        O_BPL: return !ps[7];
        O_BMI: return ps[7];
        O_BVC: return !ps[6];
        O_BVS: return ps[6];
        O_BCC: return !ps[0];
        O_BCS: return ps[0];
        O_BNE: return !ps[1];
        default: return ps[1];
      endcase
    endfunction

    // Indexed reads bump the cycle tally when the index carries into the high byte.
    function void indexed(logic [15:0] base, logic [7:0] idx);
      ea = base + {8'h00, idx};
      if (loads(op) && ea[15:8] != base[15:8]) tally = tally + 8'd1;
    endfunction

    function void data_access();
      if (op inside {O_STA, O_STX, O_STY})
        wr(ea, op == O_STA ? acc : (op == O_STX ? rx : ry), PH_WDONE);
      else
        rd(ea, PH_DATA);
    endfunction

    function void restart();
      acc = 8'h00; rx = 8'h00; ry = 8'h00; sp = 8'hFD; ps = 8'h24;
      pc = 16'h0000; opnd = 8'h00; tally = 8'h00; halt = 1'b0;
      op = O_NOP; mode = M_IMP;
      ea = 16'hFFFC;
      rd(16'hFFFC, PH_VECLO);
    endfunction

    function void decode(logic [7:0] code);
      opinfo_t e;
      e = opcode_info(code);
      if (!e.known) begin
        // Halt: keep pointing at the bad opcode, not as a fetch.
        halt = 1'b1;
        nxt.addr = pc; nxt.wr = 1'b0; nxt.wdata = 8'h00; nxt.fetch = 1'b0;
        return;
      end
      op = e.op; mode = e.mode; tally = {5'd0, e.cyc};
      pc = pc + 16'd1;
      if (mode == M_ACC) begin
        acc = shift_or_step(acc);
        opfetch();
      end else if (mode != M_IMP) begin
        rd(pc, PH_OP1);
      end else begin
        case (op)
          O_BRK: begin pc = pc + 16'd1; push(pc[15:8], PH_PUSHH); end
          O_RTS: pull(PH_RETLO);
          O_RTI: pull(PH_RTIP);
          O_PHA: push(acc, PH_WDONE);
          O_PHP: push(ps | FL_B | FL_U, PH_WDONE);
          O_PLA, O_PLP: pull(PH_PULL);
          default: begin run_implied(); opfetch(); end
        endcase
      end
    endfunction

    function void first_operand(logic [7:0] b);
      logic [15:0] dest;
      pc = pc + 16'd1;
      case (mode)
        M_IMM: begin use_operand(b); opfetch(); end
        M_REL: begin
          if (taken()) begin
            dest = pc + {{8{b[7]}}, b};
            tally = tally + 8'd1;
            if (dest[15:8] != pc[15:8]) tally = tally + 8'd1;
            pc = dest;
          end
          opfetch();
        end
        M_ZP:   begin ea = {8'h00, b}; data_access(); end
        M_ZPX:  begin ea = {8'h00, b + rx}; data_access(); end
        M_ZPY:  begin ea = {8'h00, b + ry}; data_access(); end
        M_INDX: begin ea = {8'h00, b + rx}; rd(ea, PH_PTRLO); end
        M_INDY: begin ea = {8'h00, b}; rd(ea, PH_PTRLO); end
        default: begin
          opnd = b;
          if (op == O_JSR) push(pc[15:8], PH_PUSHH);
          else rd(pc, PH_OP2);
        end
      endcase
    endfunction

    function void second_operand(logic [7:0] hi);
      logic [15:0] base;
      base = {hi, opnd};
      pc = pc + 16'd1;
      case (mode)
        M_ABSX: begin indexed(base, rx); data_access(); end
        M_ABSY: begin indexed(base, ry); data_access(); end
        M_IND:  begin ea = base; rd(base, PH_PTRLO); end
        default: begin
          if (op == O_JMP) begin pc = base; opfetch(); end
          else begin ea = base; data_access(); end
        end
      endcase
    endfunction

    function void pointer_done(logic [7:0] hi);
      logic [15:0] base;
      base = {hi, opnd};
      if (mode == M_IND) begin pc = base; opfetch(); end
      else if (mode == M_INDY) begin indexed(base, ry); data_access(); end
      else begin ea = base; data_access(); end
    endfunction

    function void advance(logic [7:0] v);
      case (step)
        PH_VECLO: begin opnd = v; rd(ea + 16'd1, PH_VECHI); end
        PH_VECHI, PH_JSRHI, PH_RETHI: begin
          pc = {v, opnd};
          if (step == PH_RETHI && op == O_RTS) pc = pc + 16'd1;
          opfetch();
        end
        PH_OPCODE: decode(v);
        PH_OP1:    first_operand(v);
        PH_OP2:    second_operand(v);
        // Pointer high byte stays in the pointer's own page.
        PH_PTRLO: begin opnd = v; rd({ea[15:8], ea[7:0] + 8'd1}, PH_PTRHI); end
        PH_PTRHI: pointer_done(v);
        PH_DATA: begin
          if (loads(op)) begin use_operand(v); opfetch(); end
          else wr(ea, shift_or_step(v), PH_WDONE);
        end
        PH_WDONE: opfetch();
        PH_PULL: begin
          if (op == O_PLA) begin acc = v; setnz(v); end
          else ps = (v & ~FL_B) | FL_U;
          opfetch();
        end
        PH_RTIP:  begin ps = (v & ~FL_B) | FL_U; pull(PH_RETLO); end
        PH_RETLO: begin opnd = v; pull(PH_RETHI); end
        PH_PUSHH: push(pc[7:0], PH_PUSHL);
        PH_PUSHL: begin
          if (op == O_JSR) rd(pc, PH_JSRHI);
          else push(ps | FL_B | FL_U, PH_BRKP);
        end
        PH_BRKP: begin
          setf(FL_I, 1'b1);
          ea = 16'hFFFE;
          rd(16'hFFFE, PH_VECLO);
        end
        default: restart();
      endcase
    endfunction

    function void note_word(logic kind, logic [7:0] data);
      access_t a;
      if (kind || step == PH_START) restart();
      else if (halt) begin
        nxt.addr = pc; nxt.wr = 1'b0; nxt.wdata = 8'h00; nxt.fetch = 1'b0;
      end else advance(data);
      a = nxt;
      a.cycles = nxt.fetch ? tally[2:0] : 3'd0;
      a.halted = halt;
      pending_access.push_back(a);
    endfunction

    function void check_access(access_t got);
      access_t want;
      if (pending_access.size() == 0) begin
        report("unexpected access", got.addr, 16'h0000);
        return;
      end
      want = pending_access.pop_front();
      if (got.addr !== want.addr) report("bus_address", got.addr, want.addr);
      if (got.wr !== want.wr) report("bus_write", got.wr, want.wr);
      if (got.wdata !== want.wdata) report("write_data", got.wdata, want.wdata);
      if (got.fetch !== want.fetch) report("opcode_fetch", got.fetch, want.fetch);
      if (got.cycles !== want.cycles) report("instruction_cycles", got.cycles, want.cycles);
      if (got.halted !== want.halted) report("halted", got.halted, want.halted);
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = 1'b0;
  logic [7:0]  read_data = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] bus_address;
  logic        bus_write;
  logic [7:0]  write_data;
  logic        opcode_fetch;
  logic [2:0]  instruction_cycles;
  logic        halted;

  bus_predictor shadow = new();
  bit           quiet;        // stretch with no idling on either side
  bit           hold_off_due; // raised by the sender, served by the receiver
  int unsigned  cycle_count;

  cpu_6502_core i_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .kind_i              (kind),
    .read_data_i         (read_data),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .bus_address_o       (bus_address),
    .bus_write_o         (bus_write),
    .write_data_o        (write_data),
    .opcode_fetch_o      (opcode_fetch),
    .instruction_cycles_o(instruction_cycles),
    .halted_o            (halted)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  // Offer one word, idling first unless quiet; note it with the shadow core once accepted.
  task automatic send_word(logic k, logic [7:0] d);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    read_data <= d;
    do @(posedge clk); while (!(in_valid && !in_stall));
    shadow.note_word(k, d);
  endtask

  // Bias data bytes towards the extremes now and then.
  function automatic logic [7:0] data_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  // Receiver: stall at random, when asked for a long stretch, then take one word.
  initial begin : receive
    int unsigned wait_n;
    access_t     got;
    forever begin
      if (hold_off_due) begin
        hold_off_due = 1'b0;
        wait_n = HoldOffLen;
      end else begin
        wait_n = quiet ? 0 : $urandom_range(0, 18);
      end
      repeat (wait_n) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      got.addr   = bus_address;
      got.wr     = bus_write;
      got.wdata  = write_data;
      got.fetch  = opcode_fetch;
      got.cycles = instruction_cycles;
      got.halted = halted;
      shadow.check_access(got);
    end
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned drain;
    logic [7:0]  b;
    logic [7:0]  prog[$];
    opinfo_t     info;
    cycle_count  = 0;
    quiet        = 1'b0;
    hold_off_due = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: vector FFFF so the program wraps to 0000, overflow and carry
    // on ADC, accumulator shift, a backward branch not taken as carry is clear,
    // BRK with its pushes and vector, JMP indirect through a page end,
    // then an unknown opcode that halts until reset.
    send_word(1'b1, 8'h00);
    prog = {8'hFF, 8'hFF, 8'hA9, 8'h80, 8'h69, 8'h80, 8'hE9, 8'h00, 8'h0A,
            8'hB0, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h34, 8'h12,
            8'h6C, 8'hFF, 8'h02, 8'h00, 8'h10, 8'h02, 8'hFF};
    foreach (prog[i]) send_word(1'b0, prog[i]);
    send_word(1'b1, 8'hFF);

    sent = 0;
    while (sent < RandomWords) begin
      if (sent % 250 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (sent == 600) hold_off_due = 1'b1;
      if (shadow.halt) begin
        // Idle words while halted; bring the core back soon.
        if ($urandom_range(0, 2) == 0) send_word(1'b1, 8'($urandom));
        else send_word(1'b0, 8'($urandom));
        continue;
      end
      if ($urandom_range(0, 99) == 0) begin
        send_word(1'b1, 8'($urandom));
      end else if (shadow.nxt.fetch) begin
        // Mostly documented opcodes; a few raw bytes reach the halt path.
        b = 8'($urandom);
        if ($urandom_range(0, 29) != 0) begin
          info = opcode_info(b);
          while (!info.known) begin
            b = 8'($urandom);
            info = opcode_info(b);
          end
        end
        send_word(1'b0, b);
      end else begin
        send_word(1'b0, data_byte());
      end
      sent++;
    end
    in_valid <= 1'b0;

    while (shadow.pending_access.size() != 0) @(posedge clk);
    for (drain = 0; drain < 20; drain++) @(posedge clk);
    if (shadow.mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
